[rtl/dqe_pkg.sv]
// Shared types, constants and index helpers for the double-ended queue engine.
package dqe_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_REV,
    OP_LIST
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_e;

  // Classified command as it travels from the front part to the back part.
  typedef struct packed {
    op_e                       op;
    logic                      at_back;  // logical end: 0 front, 1 back
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Ring slot at a logical offset from the first slot, offset in 0..CAPACITY.
  function automatic logic [PTR_W-1:0] phys_addr(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + {1'b0, off};
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(CAPACITY - 1)) ? '0 : s + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] s);
    return (s == '0) ? PTR_W'(CAPACITY - 1) : s - PTR_W'(1);
  endfunction

endpackage

[rtl/dqe_front.sv]
// Input side: takes command transfers, classifies them and buffers them in a short queue.
module dqe_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dqe_pkg::VALUE_W-1:0]   s_axis_tdata_i,
  input  logic [dqe_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output dqe_pkg::cmd_t                 cmd_o
);

  dqe_pkg::cmd_t                     buf_q [dqe_pkg::QUEUE_DEPTH];
  logic [dqe_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [dqe_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [dqe_pkg::QCNT_W-1:0]        count_q, count_d;
  dqe_pkg::cmd_t                     cls;
  logic                              cls_ok;
  logic                              wr_en;
  logic                              rd_en;

  always_comb begin
    cls.value   = $signed(s_axis_tdata_i);
    cls.at_back = 1'b0;
    cls.op      = dqe_pkg::OP_PUSH;
    cls_ok      = 1'b1;
    case (s_axis_tuser_i)
      dqe_pkg::CMD_PUSH_FRONT: cls.op = dqe_pkg::OP_PUSH;
      dqe_pkg::CMD_PUSH_BACK: begin
        cls.op      = dqe_pkg::OP_PUSH;
        cls.at_back = 1'b1;
      end
      dqe_pkg::CMD_POP_FRONT: cls.op = dqe_pkg::OP_POP;
      dqe_pkg::CMD_POP_BACK: begin
        cls.op      = dqe_pkg::OP_POP;
        cls.at_back = 1'b1;
      end
      dqe_pkg::CMD_REVERSE: cls.op = dqe_pkg::OP_REV;
      dqe_pkg::CMD_LIST:    cls.op = dqe_pkg::OP_LIST;
      default:              cls_ok = 1'b0;  // unused codes are dropped silently
    endcase
  end

  assign s_axis_tready_o = (count_q != dqe_pkg::QCNT_W'(dqe_pkg::QUEUE_DEPTH));
  assign wr_en           = s_axis_tvalid_i && s_axis_tready_o && cls_ok;
  assign cmd_valid_o     = (count_q != '0);
  assign rd_en           = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? ((wr_ptr_q == dqe_pkg::QPTR_W'(dqe_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : wr_ptr_q + dqe_pkg::QPTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = rd_en ? ((rd_ptr_q == dqe_pkg::QPTR_W'(dqe_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : rd_ptr_q + dqe_pkg::QPTR_W'(1)) : rd_ptr_q;
    count_d  = count_q + dqe_pkg::QCNT_W'(wr_en) - dqe_pkg::QCNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/dqe_back.sv]
// Execution side: ring storage, pointers, orientation flag and the result register.
module dqe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  dqe_pkg::cmd_t                 cmd_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dqe_pkg::VALUE_W-1:0]   m_axis_tdata_o,
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  logic signed [dqe_pkg::VALUE_W-1:0] mem [dqe_pkg::CAPACITY];
  logic signed [dqe_pkg::VALUE_W-1:0] rd_data_q;
  logic                               rd_en;
  logic [dqe_pkg::PTR_W-1:0]          rd_addr;
  logic                               wr_en;
  logic [dqe_pkg::PTR_W-1:0]          wr_addr;

  dqe_pkg::state_e                    state_q, state_d;
  logic [dqe_pkg::PTR_W-1:0]          front_q, front_d;
  logic [dqe_pkg::CNT_W-1:0]          occ_q, occ_d;
  logic                               rev_q, rev_d;
  logic [dqe_pkg::CNT_W-1:0]          idx_q, idx_d;

  logic                               out_vld_q, out_vld_d;
  dqe_pkg::status_e                   out_status_q, out_status_d;
  logic signed [dqe_pkg::VALUE_W-1:0] out_data_q, out_data_d;
  logic                               out_last_q, out_last_d;

  logic                               out_free;
  logic                               phys_front;
  logic                               list_end;
  logic [dqe_pkg::CNT_W-1:0]          occ_m1;
  logic [dqe_pkg::CNT_W-1:0]          idx_nx;
  logic [dqe_pkg::CNT_W-1:0]          first_off;
  logic [dqe_pkg::CNT_W-1:0]          next_off;

  assign out_free   = !out_vld_q || m_axis_tready_i;
  // the logical end maps to the physical front unless exactly one of the two flips it
  assign phys_front = (cmd_i.at_back == rev_q);
  assign occ_m1     = occ_q - dqe_pkg::CNT_W'(1);
  assign list_end   = (idx_q == occ_m1);
  assign idx_nx     = idx_q + dqe_pkg::CNT_W'(1);
  assign first_off  = rev_q ? occ_m1 : '0;
  assign next_off   = rev_q ? (occ_m1 - idx_nx) : idx_nx;

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    occ_d        = occ_q;
    rev_d        = rev_q;
    idx_d        = idx_q;
    cmd_ready_o  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = front_q;
    wr_en        = 1'b0;
    wr_addr      = front_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;

    case (state_q)
      dqe_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o  = 1'b1;
          out_status_d = dqe_pkg::ST_OK;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          case (cmd_i.op)
            dqe_pkg::OP_PUSH: begin
              out_vld_d = 1'b1;
              if (occ_q == dqe_pkg::CNT_W'(dqe_pkg::CAPACITY)) begin
                out_status_d = dqe_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                occ_d = occ_q + dqe_pkg::CNT_W'(1);
                if (phys_front) begin
                  front_d = dqe_pkg::slot_dec(front_q);
                  wr_addr = dqe_pkg::slot_dec(front_q);
                end else begin
                  wr_addr = dqe_pkg::phys_addr(front_q, occ_q);
                end
              end
            end
            dqe_pkg::OP_POP: begin
              if (occ_q == '0) begin
                out_vld_d    = 1'b1;
                out_status_d = dqe_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                occ_d   = occ_m1;
                state_d = dqe_pkg::S_POP;
                if (phys_front) begin
                  rd_addr = front_q;
                  front_d = dqe_pkg::slot_inc(front_q);
                end else begin
                  rd_addr = dqe_pkg::phys_addr(front_q, occ_m1);
                end
              end
            end
            dqe_pkg::OP_REV: begin
              out_vld_d = 1'b1;
              if (occ_q == '0) begin
                out_status_d = dqe_pkg::ST_EMPTY;
              end else begin
                rev_d = !rev_q;
              end
            end
            dqe_pkg::OP_LIST: begin
              if (occ_q == '0) begin
                out_vld_d    = 1'b1;
                out_status_d = dqe_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = dqe_pkg::phys_addr(front_q, first_off);
                idx_d   = '0;
                state_d = dqe_pkg::S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      dqe_pkg::S_POP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = dqe_pkg::ST_OK;
          out_data_d   = rd_data_q;
          out_last_d   = 1'b1;
          state_d      = dqe_pkg::S_IDLE;
        end
      end
      dqe_pkg::S_LIST: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = dqe_pkg::ST_OK;
          out_data_d   = rd_data_q;
          out_last_d   = list_end;
          if (list_end) begin
            state_d = dqe_pkg::S_IDLE;
          end else begin
            // fetch the next entry while this one goes out
            rd_en   = 1'b1;
            rd_addr = dqe_pkg::phys_addr(front_q, next_off);
            idx_d   = idx_nx;
          end
        end
      end
      default: state_d = dqe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dqe_pkg::S_IDLE;
      front_q   <= '0;
      occ_q     <= '0;
      rev_q     <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      occ_q     <= occ_d;
      rev_q     <= rev_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

[rtl/double_ended_queue_engine.sv]
// Top level of the double-ended queue engine: command queue front end and execution back end.
//
//   channel   direction  tdata                tuser           tlast
//   s_axis    in         value[31:0]          cmd[2:0]        -
//   m_axis    out        data[31:0]           status[1:0]     last
//
// Push and reverse finish in the back end's idle state; pop goes through a registered ring
// read and S_POP; list runs in S_LIST, reading entry after entry through the single read port.
// Two commands can wait in the front queue while the back end works or stalls.
// Reset (rst_ni low) empties the queue and clears pointers, count and orientation.
// A stalled result holds in the output register; the back end waits until it is taken.
module double_ended_queue_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] data
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  dqe_pkg::cmd_t cmd;

  dqe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  dqe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[bench/tb_double_ended_queue_engine.sv]
// Self-checking testbench for the double-ended queue engine: directed and random commands.
module tb_double_ended_queue_engine;
  import dqe_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_GOAL   = 410;  // directed part plus random commands, counting valid codes only
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [CMD_W-1:0]   code;
    logic [VALUE_W-1:0] value;
    bit                 hold;   // wait until every reply is back before sending
  } cmd_item_t;

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
  } reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_valid = 1'b0;
  logic [VALUE_W-1:0] s_data  = '0;
  logic [CMD_W-1:0]   s_user  = '0;
  logic               m_ready = 1'b0;

  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [VALUE_W-1:0] m_axis_tdata_o;
  logic [1:0]         m_axis_tuser_o;
  logic               m_axis_tlast_o;

  double_ended_queue_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  cmd_item_t cmd_q[$];
  reply_t    reply_q[$];
  cmd_item_t next_cmd;
  reply_t    want;

  int  made_cnt  = 0;
  int  gen_fill  = 0;
  bit  hold_next = 1'b0;
  int  stim_total = 1;
  int  sent_cnt  = 0;
  int  err_cnt   = 0;
  int  cycle_cnt = 0;

  // Shadow deque
  logic signed [VALUE_W-1:0] ring [CAPACITY];
  logic [PTR_W-1:0]          head_slot = '0;
  logic [CNT_W-1:0]          fill      = '0;
  logic                      flipped   = 1'b0;

  function automatic logic [PTR_W-1:0] ring_slot(input int off);
    return PTR_W'((int'(head_slot) + off) % CAPACITY);
  endfunction

  task automatic add_reply(input status_e st, input logic signed [VALUE_W-1:0] d,
                           input logic lst);
    reply_q.push_back('{status: st, data: d, last: lst});
  endtask

  // Apply one accepted command to the shadow deque and queue its replies.
  task automatic run_deque_cmd(input logic [CMD_W-1:0] code,
                               input logic signed [VALUE_W-1:0] value);
    logic signed [VALUE_W-1:0] v;
    int off;
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill == CNT_W'(CAPACITY)) begin
          add_reply(ST_FULL, '0, 1'b1);
        end else begin
          if ((code == CMD_PUSH_FRONT) != flipped) begin
            head_slot = ring_slot(CAPACITY - 1);
            ring[head_slot] = value;
          end else begin
            ring[ring_slot(int'(fill))] = value;
          end
          fill = fill + 1'b1;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == '0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          if ((code == CMD_POP_FRONT) != flipped) begin
            v = ring[head_slot];
            head_slot = ring_slot(1);
          end else begin
            v = ring[ring_slot(int'(fill) - 1)];
          end
          fill = fill - 1'b1;
          add_reply(ST_OK, v, 1'b1);
        end
      end
      CMD_REVERSE: begin
        if (fill == '0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          flipped = ~flipped;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (fill == '0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(fill); i++) begin
            off = flipped ? int'(fill) - 1 - i : i;
            add_reply(ST_OK, ring[ring_slot(off)], (i + 1 == int'(fill)));
          end
        end
      end
      default: ;  // unused codes are dropped silently
    endcase
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] value);
    cmd_q.push_back('{code: code, value: value, hold: hold_next});
    hold_next = 1'b0;
    if (code <= CMD_LIST) made_cnt++;
    if ((code == CMD_PUSH_FRONT || code == CMD_PUSH_BACK) && gen_fill < CAPACITY)
      gen_fill++;
    else if ((code == CMD_POP_FRONT || code == CMD_POP_BACK) && gen_fill > 0)
      gen_fill--;
  endtask

  function automatic logic [VALUE_W-1:0] rnd_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rnd_push();
    return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
  endfunction

  function automatic logic [CMD_W-1:0] rnd_pop();
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  // Idle percentage per phase: sender light/receiver heavy, swapped, then none.
  function automatic int idle_pct(input bit recv_side);
    if (sent_cnt * 3 < stim_total) return recv_side ? 76 : 24;
    if (sent_cnt * 3 < 2 * stim_total) return recv_side ? 24 : 76;
    return 0;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0d: %s", cycle_cnt, msg);
  endtask

  // Driver: one command transfer per handshake, fed from cmd_q
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        run_deque_cmd(s_user, s_data);
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0) &&
            !(cmd_q[0].hold && reply_q.size() != 0)) begin
          next_cmd = cmd_q.pop_front();
          s_valid  <= 1'b1;
          s_data   <= next_cmd.value;
          s_user   <= next_cmd.code;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest predicted reply
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (reply_q.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d data %h last %0d",
                               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tuser_o !== want.status || m_axis_tdata_o !== want.data ||
              m_axis_tlast_o !== want.last)
            flag_error($sformatf("status %0d/%0d data %h/%h last %0d/%0d (exp/act)",
                                 want.status, m_axis_tuser_o, want.data, m_axis_tdata_o,
                                 want.last, m_axis_tlast_o));
        end
      end
      m_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL double_ended_queue_engine");
    $finish;
  end

  initial begin
    // empty deque: every command but push reports empty
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(CMD_POP_FRONT, 32'h0);
    add_cmd(CMD_POP_BACK, 32'h1234_5678);
    add_cmd(CMD_REVERSE, 32'h0);
    add_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    add_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    add_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    add_cmd(CMD_PUSH_BACK, 32'h5A5A_A5A5);
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(CMD_REVERSE, 32'h0);
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(CMD_POP_FRONT, 32'h0);
    add_cmd(CMD_POP_BACK, 32'h0);
    add_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
    add_cmd(CMD_PUSH_BACK, 32'h0000_0002);
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(3'd6, 32'hFFFF_FFFF);
    add_cmd(3'd7, 32'h0);
    add_cmd(CMD_REVERSE, 32'h0);
    add_cmd(CMD_POP_FRONT, 32'h0);
    hold_next = 1'b1;  // sender waits for all replies before this one
    add_cmd(CMD_POP_BACK, 32'h0);
    add_cmd(CMD_LIST, 32'h0);

    while (made_cnt < ITEM_GOAL) begin
      hold_next = ($urandom_range(0, 24) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill up and run into full
          while (gen_fill < CAPACITY) add_cmd(rnd_push(), rnd_value());
          if ($urandom_range(0, 1)) add_cmd(CMD_REVERSE, $urandom());
          repeat ($urandom_range(1, 2)) add_cmd(rnd_push(), rnd_value());
          add_cmd(CMD_LIST, $urandom());
        end
        2: begin
          while (gen_fill > 0) add_cmd(rnd_pop(), $urandom());
          add_cmd(rnd_pop(), $urandom());
        end
        3: add_cmd($urandom_range(0, 1) ? 3'd7 : 3'd6, $urandom());
        default: begin
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6:        add_cmd(rnd_push(), rnd_value());
              7, 8, 9, 10, 11, 12, 13:    add_cmd(rnd_pop(), $urandom());
              14, 15, 16:                 add_cmd(CMD_REVERSE, $urandom());
              default:                    add_cmd(CMD_LIST, $urandom());
            endcase
          end
        end
      endcase
    end
    stim_total = cmd_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // checked at the falling edge so all transfers of the rising edge have settled
    do @(negedge clk_i); while (cmd_q.size() != 0 || s_valid || reply_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("PASS double_ended_queue_engine");
    end else begin
      $display("FAIL double_ended_queue_engine");
    end
    $finish;
  end

endmodule

[double_ended_queue_engine.f]
rtl/dqe_pkg.sv
rtl/dqe_front.sv
rtl/dqe_back.sv
rtl/double_ended_queue_engine.sv
bench/tb_double_ended_queue_engine.sv
